// File: hw/rtl/fira_pkg.sv
package fira_pkg;

    localparam int MAX_RANGES_DEF   = 16;
    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int FIELD_W          = 32;

    localparam logic [1:0] ACT_TAKE    = 2'd0;
    localparam logic [1:0] ACT_EXCLUDE = 2'd1;
    localparam logic [1:0] ACT_ADD     = 2'd2;
    localparam logic [1:0] ACT_SPARE   = 2'd3;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_A,
        ST_B,
        ST_FIN,
        ST_FL,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/fira_ram.sv
module fira_ram #(
    parameter int W = 64,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/free_id_range_allocator.sv
// Free number range allocator. The pool of free numbers is held as a sorted
// table of disjoint, non-touching ranges in a ping-pong RAM (two banks in one
// RAM, each of MAX_RANGES rounded up to a power of two entries). Each operation
// streams the live bank through a single merge/append unit and builds the new
// table in the other bank; the banks swap only if the new table fits, so a
// refused operation (status 1) leaves the pool untouched. An item reads (RD),
// passes each stored range through the shared merge unit in two phases (A, B),
// appends an add that lands after the last range (FIN), commits (FL) and
// returns its result. With an empty pool there is nothing to read: an exclude
// goes straight to the commit and an add appends first. Take with an empty
// pool, reversed ranges and the unused action code skip the table. The input is
// not ready while an item is in work; one result register holds the finished
// result so the next transfer can be taken. Writing first_number or last_number
// reloads the pool with the one range between them (empty if reversed).
// No clearing pass is needed after reset.
module free_id_range_allocator #(
    parameter int MAX_RANGES   = fira_pkg::MAX_RANGES_DEF,
    parameter int NUMBER_WIDTH = fira_pkg::NUMBER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // action[1:0], range_start[33:2], range_end[65:34], zero pad
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // taken_number[31:0], taken_valid[32], pool_empty[33], status[34], pad
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    localparam int NW   = NUMBER_WIDTH;
    localparam int AW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW   = $clog2(MAX_RANGES + 2);
    localparam int FW   = fira_pkg::FIELD_W;
    localparam logic [CW-1:0] CMAX  = CW'(MAX_RANGES);
    localparam logic [CW-1:0] CMAX1 = CW'(MAX_RANGES + 1);

    fira_pkg::t_state r_state, n_state;

    logic [NW-1:0] r_first, r_last, n_first, n_last;
    logic [NW-1:0] cfg_val, init_lo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_init, n_init;
    logic          r_bank, n_bank;
    logic [AW-1:0] r_i, n_i;
    logic [1:0]    r_act, n_act;
    logic [NW-1:0] r_rs, n_rs, r_re, n_re;
    logic [NW-1:0] r_ts, n_ts, r_te, n_te;
    logic          r_tv, n_tv, r_placed, n_placed;
    logic [CW-1:0] r_oc, n_oc;
    logic [NW-1:0] r_taken, n_taken;
    logic          r_tvld, n_tvld, r_stat, n_stat;
    logic          r_ov, n_ov;
    logic [34:0]   r_od, n_od;

    logic [NW-1:0] in_rs, in_re, ent_s, ent_e, c_s, c_e;
    logic          c_v, mrg;
    logic          we;
    logic [AW:0]   waddr, raddr;
    logic [2*NW-1:0] rdata;
    logic [CW-1:0] i_next;

    // transfer fields
    assign in_rs = (NW'(s_axis_tdata[33:2]) == '0) ? NW'(1) : NW'(s_axis_tdata[33:2]);
    assign in_re = NW'(s_axis_tdata[65:34]);
    assign cfg_val = NW'(i_cfg_wdata);
    assign init_lo = (r_first == '0) ? NW'(1) : r_first;

    fira_ram #(.W(2 * NW), .D(2 * (1 << AW))) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata({r_te, r_ts}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // entry zero comes from the registers until the first commit
    always_comb begin
        if (r_init && r_i == '0) begin
            ent_s = init_lo;
            ent_e = r_last;
        end else begin
            ent_s = rdata[NW-1:0];
            ent_e = rdata[2*NW-1:NW];
        end
    end

    assign i_next = CW'(r_i) + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_act    = r_act;
        n_rs     = r_rs;
        n_re     = r_re;
        n_ts     = r_ts;
        n_te     = r_te;
        n_tv     = r_tv;
        n_placed = r_placed;
        n_oc     = r_oc;
        n_taken  = r_taken;
        n_tvld   = r_tvld;
        n_stat   = r_stat;
        n_cnt    = r_cnt;
        n_bank   = r_bank;
        n_init   = r_init;
        n_ov     = r_ov;
        n_od     = r_od;
        c_v      = 1'b0;
        c_s      = ent_s;
        c_e      = ent_e;
        we       = 1'b0;
        raddr    = {r_bank, r_i};
        waddr    = {~r_bank, AW'(r_oc - CW'(1))};
        s_axis_tready = (r_state == fira_pkg::ST_IDLE);

        if (m_axis_tvalid && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            fira_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act    = s_axis_tdata[1:0];
                    n_rs     = in_rs;
                    n_re     = in_re;
                    n_i      = '0;
                    n_tv     = 1'b0;
                    n_oc     = '0;
                    n_placed = 1'b0;
                    n_taken  = '0;
                    n_tvld   = 1'b0;
                    n_stat   = 1'b0;
                    n_state  = fira_pkg::ST_DONE;
                    if ((s_axis_tdata[1:0] == fira_pkg::ACT_TAKE && r_cnt != '0)
                        || ((s_axis_tdata[1:0] inside {fira_pkg::ACT_EXCLUDE,
                                                       fira_pkg::ACT_ADD})
                            && in_rs <= in_re)) begin
                        if (r_cnt != '0) begin
                            n_state = fira_pkg::ST_RD;
                        end else if (s_axis_tdata[1:0] == fira_pkg::ACT_ADD) begin
                            n_state = fira_pkg::ST_FIN;
                        end else begin
                            n_state = fira_pkg::ST_FL;
                        end
                    end
                end
            end
            fira_pkg::ST_RD: begin
                n_state = fira_pkg::ST_A;
            end
            fira_pkg::ST_A: begin
                case (r_act)
                    fira_pkg::ACT_TAKE: begin
                        if (r_i == '0) begin
                            n_taken = ent_s;
                            n_tvld  = 1'b1;
                            c_v     = (ent_s != ent_e);
                            c_s     = ent_s + NW'(1);
                        end else begin
                            c_v = 1'b1;
                        end
                    end
                    fira_pkg::ACT_EXCLUDE: begin
                        c_v = (ent_s < r_rs);
                        c_e = (ent_e < r_rs) ? ent_e : r_rs - NW'(1);
                    end
                    default: begin
                        if (!r_placed && ent_s >= r_rs) begin
                            c_v      = 1'b1;
                            c_s      = r_rs;
                            c_e      = r_re;
                            n_placed = 1'b1;
                        end
                    end
                endcase
                n_state = fira_pkg::ST_B;
            end
            fira_pkg::ST_B: begin
                case (r_act)
                    fira_pkg::ACT_EXCLUDE: begin
                        c_v = (ent_e > r_re);
                        c_s = (ent_s > r_re) ? ent_s : r_re + NW'(1);
                    end
                    fira_pkg::ACT_ADD: begin
                        c_v = 1'b1;
                    end
                    default: c_v = 1'b0;
                endcase
                raddr = {r_bank, AW'(i_next)};
                if (i_next < r_cnt) begin
                    n_i     = AW'(i_next);
                    n_state = fira_pkg::ST_A;
                end else if (r_act == fira_pkg::ACT_ADD && !r_placed) begin
                    n_state = fira_pkg::ST_FIN;
                end else begin
                    n_state = fira_pkg::ST_FL;
                end
            end
            fira_pkg::ST_FIN: begin
                c_v     = 1'b1;
                c_s     = r_rs;
                c_e     = r_re;
                n_state = fira_pkg::ST_FL;
            end
            fira_pkg::ST_FL: begin
                we = r_tv && (r_oc <= CMAX);
                if (r_oc <= CMAX) begin
                    n_bank = ~r_bank;
                    n_cnt  = r_oc;
                    n_init = 1'b0;
                end else begin
                    n_stat = 1'b1;
                end
                n_state = fira_pkg::ST_DONE;
            end
            fira_pkg::ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_od    = {r_stat, (r_cnt == '0), r_tvld, FW'(r_taken)};
                    n_state = fira_pkg::ST_IDLE;
                end
            end
            default: n_state = fira_pkg::ST_IDLE;
        endcase

        // shared merge/append unit: tail entry stays in registers
        mrg = r_tv && (c_s - NW'(1) <= r_te);
        if (c_v) begin
            if (mrg) begin
                if (c_e > r_te) begin
                    n_te = c_e;
                end
            end else begin
                we   = r_tv && (r_oc <= CMAX);
                n_ts = c_s;
                n_te = c_e;
                n_tv = 1'b1;
                n_oc = (r_oc == CMAX1) ? r_oc : r_oc + CW'(1);
            end
        end

        // configuration reloads the pool
        n_first = r_first;
        n_last  = r_last;
        if (i_cfg_we) begin
            if (i_cfg_idx == fira_pkg::CFG_FIRST) begin
                n_first = cfg_val;
            end else begin
                n_last = cfg_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fira_pkg::ST_IDLE;
            r_first <= NW'(1);
            r_last  <= NW'(32'hFFFF_FFFF);
            r_cnt   <= CW'(1);
            r_init  <= 1'b1;
            r_bank  <= 1'b0;
            r_ov    <= 1'b0;
            r_tv    <= 1'b0;
            r_oc    <= '0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_bank  <= n_bank;
            r_ov    <= n_ov;
            r_tv    <= n_tv;
            r_oc    <= n_oc;
            if (i_cfg_we) begin
                r_init <= 1'b1;
                r_cnt  <= ((n_first == '0 ? NW'(1) : n_first) <= n_last) ? CW'(1) : '0;
            end else begin
                r_init <= n_init;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_act    <= n_act;
        r_rs     <= n_rs;
        r_re     <= n_re;
        r_ts     <= n_ts;
        r_te     <= n_te;
        r_placed <= n_placed;
        r_taken  <= n_taken;
        r_tvld   <= n_tvld;
        r_stat   <= n_stat;
        r_od     <= n_od;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b0, r_od};

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fira_pkg::ST_IDLE |-> !we)
        else $error("table write while idle");
    a_cnt_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CMAX)
        else $error("range count above capacity");
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != $past(r_bank) |-> $past(r_state) == fira_pkg::ST_FL)
        else $error("bank swap outside commit");
    a_oc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oc <= CMAX1)
        else $error("build count overrun");
endmodule
